@@ rtl/crb_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// crb_pkg
// Shared constants, codes and types of the clipped rectangle blitter.
// ----------------------------------------------------------------------------
package crb_pkg;

   localparam int MAX_WIDTH  = 1024;
   localparam int MAX_HEIGHT = 512;
   localparam int SURF_DEPTH = MAX_WIDTH * MAX_HEIGHT;
   localparam int ADDR_W     = $clog2(SURF_DEPTH);

   localparam int PIX_W      = 8;
   localparam int CRD_W      = 16;
   localparam int OP_W       = 3;
   localparam int SEL_W      = 3;
   localparam int POS_W      = 12;
   localparam int SIZE_W     = 11;
   localparam int DRAWN_W_W  = 11;
   localparam int DRAWN_H_W  = 10;
   localparam int SURF_WREG_W = 11;
   localparam int SURF_HREG_W = 10;
   localparam int OFF_W      = 11;

   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 11;

   localparam logic [PIX_W-1:0] MASK_COLOUR = 8'd8;
   localparam int SURF_WIDTH_RESET  = 640;
   localparam int SURF_HEIGHT_RESET = 400;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SURF0_WIDTH,
      CSR_SURF0_HEIGHT,
      CSR_SURF1_WIDTH,
      CSR_SURF1_HEIGHT,
      CSR_SURF0_OFFSET_X,
      CSR_SURF0_OFFSET_Y,
      CSR_SURF1_OFFSET_X,
      CSR_SURF1_OFFSET_Y
   } csr_index_type;

   typedef enum logic [OP_W-1:0] {
      OP_FILL,
      OP_COPY,
      OP_MASKED_COPY,
      OP_SWAP,
      OP_COMPOSE,
      OP_WRITE_PIXEL,
      OP_READ_PIXEL,
      OP_NOP
   } op_type;

   typedef logic signed [CRD_W-1:0] crd_type;
   typedef logic [ADDR_W-1:0] addr_type;

   typedef enum logic [2:0] {
      CLIP_LEFT_A,
      CLIP_TOP_A,
      CLIP_LEFT_B,
      CLIP_TOP_B,
      CLIP_RIGHT_A,
      CLIP_BOTTOM_A,
      CLIP_RIGHT_B,
      CLIP_BOTTOM_B
   } clip_step_type;

   typedef struct packed {
      crd_type ax;
      crd_type ay;
      crd_type bx;
      crd_type by;
      crd_type w;
      crd_type h;
   } clip_rect_type;

   typedef struct packed {
      crd_type wa;
      crd_type ha;
      crd_type wb;
      crd_type hb;
   } clip_bounds_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CLIP,
      ST_SETUP,
      ST_WALK,
      ST_PIXEL_CHECK,
      ST_PIXEL_ADDR,
      ST_PIXEL_ACCESS,
      ST_PIXEL_READ,
      ST_FINISH
   } state_type;

endpackage
`default_nettype wire

@@ rtl/crb_if.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// crb_if
// Request and response channels of the blitter, valid/ready handshake.
// ----------------------------------------------------------------------------
interface crb_req_if import crb_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic [OP_W-1:0]         op;
   logic [SEL_W-1:0]        surface_sel;
   logic signed [POS_W-1:0] dst_x;
   logic signed [POS_W-1:0] dst_y;
   logic signed [POS_W-1:0] src_x;
   logic signed [POS_W-1:0] src_y;
   logic signed [POS_W-1:0] bg_x;
   logic signed [POS_W-1:0] bg_y;
   logic [SIZE_W-1:0]       width;
   logic [SIZE_W-1:0]       height;
   logic [PIX_W-1:0]        pixel_value;

   modport source (output valid, op, surface_sel, dst_x, dst_y, src_x, src_y, bg_x, bg_y,
                   width, height, pixel_value, input ready);
   modport sink (input valid, op, surface_sel, dst_x, dst_y, src_x, src_y, bg_x, bg_y,
                 width, height, pixel_value, output ready);
endinterface

interface crb_rsp_if import crb_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [PIX_W-1:0]     read_data;
   logic [DRAWN_W_W-1:0] drawn_width;
   logic [DRAWN_H_W-1:0] drawn_height;
   logic                 status;

   modport source (output valid, read_data, drawn_width, drawn_height, status, input ready);
   modport sink (input valid, read_data, drawn_width, drawn_height, status, output ready);
endinterface
`default_nettype wire

@@ rtl/clipped_rectangle_blitter_core.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// clipped_rectangle_blitter_core
// Two 8-bit indexed surfaces with fill, copy, masked copy, swap, compose and
// single pixel write and read, rectangles clipped to the surface sizes.
// ----------------------------------------------------------------------------
// One request at a time. A rectangle request is taken, clipped (twice for
// compose), set up and walked row by row: fill only writes, copy and masked
// copy read then write, compose reads source and background then writes,
// swap reads and writes both pixels, as every surface RAM has one read and
// one write port. An empty clip skips the walk. Pixel write and read check
// bounds and set the address first. The finish state passes the response
// to the output register, waiting while it holds an untaken one; the
// register can hold a response while the next request is taken. Pixels
// never written read back as arbitrary values; there is no clearing pass.
// ----------------------------------------------------------------------------
module clipped_rectangle_blitter_core import crb_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   crb_req_if.sink               req_bus,
   crb_rsp_if.source             rsp_bus,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wr_data
);

   // configuration registers
   logic [SURF_WREG_W-1:0]  surf0_width_ff, surf1_width_ff;
   logic [SURF_HREG_W-1:0]  surf0_height_ff, surf1_height_ff;
   logic signed [OFF_W-1:0] surf0_offset_x_ff, surf0_offset_y_ff;
   logic signed [OFF_W-1:0] surf1_offset_x_ff, surf1_offset_y_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         surf0_width_ff    <= SURF_WREG_W'(SURF_WIDTH_RESET);
         surf0_height_ff   <= SURF_HREG_W'(SURF_HEIGHT_RESET);
         surf1_width_ff    <= SURF_WREG_W'(SURF_WIDTH_RESET);
         surf1_height_ff   <= SURF_HREG_W'(SURF_HEIGHT_RESET);
         surf0_offset_x_ff <= '0;
         surf0_offset_y_ff <= '0;
         surf1_offset_x_ff <= '0;
         surf1_offset_y_ff <= '0;
      end else if (csr_wr_en) begin
         unique case (csr_index_type'(csr_index))
            CSR_SURF0_WIDTH:    surf0_width_ff    <= csr_wr_data[SURF_WREG_W-1:0];
            CSR_SURF0_HEIGHT:   surf0_height_ff   <= csr_wr_data[SURF_HREG_W-1:0];
            CSR_SURF1_WIDTH:    surf1_width_ff    <= csr_wr_data[SURF_WREG_W-1:0];
            CSR_SURF1_HEIGHT:   surf1_height_ff   <= csr_wr_data[SURF_HREG_W-1:0];
            CSR_SURF0_OFFSET_X: surf0_offset_x_ff <= csr_wr_data[OFF_W-1:0];
            CSR_SURF0_OFFSET_Y: surf0_offset_y_ff <= csr_wr_data[OFF_W-1:0];
            CSR_SURF1_OFFSET_X: surf1_offset_x_ff <= csr_wr_data[OFF_W-1:0];
            CSR_SURF1_OFFSET_Y: surf1_offset_y_ff <= csr_wr_data[OFF_W-1:0];
         endcase
      end
   end

   // sizes limited to the store
   crd_type eff_w0, eff_w1, eff_h0, eff_h1;
   crd_type off_x0, off_x1, off_y0, off_y1;

   assign eff_w0 = (CRD_W'(surf0_width_ff) > CRD_W'(MAX_WIDTH)) ?
                   CRD_W'(MAX_WIDTH) : CRD_W'(surf0_width_ff);
   assign eff_w1 = (CRD_W'(surf1_width_ff) > CRD_W'(MAX_WIDTH)) ?
                   CRD_W'(MAX_WIDTH) : CRD_W'(surf1_width_ff);
   assign eff_h0 = (CRD_W'(surf0_height_ff) > CRD_W'(MAX_HEIGHT)) ?
                   CRD_W'(MAX_HEIGHT) : CRD_W'(surf0_height_ff);
   assign eff_h1 = (CRD_W'(surf1_height_ff) > CRD_W'(MAX_HEIGHT)) ?
                   CRD_W'(MAX_HEIGHT) : CRD_W'(surf1_height_ff);
   assign off_x0 = CRD_W'(surf0_offset_x_ff);
   assign off_x1 = CRD_W'(surf1_offset_x_ff);
   assign off_y0 = CRD_W'(surf0_offset_y_ff);
   assign off_y1 = CRD_W'(surf1_offset_y_ff);

   function automatic logic [1:0] last_phase(input op_type op);
      logic [1:0] p;
      unique case (op)
         OP_FILL:                 p = 2'd0;
         OP_COPY, OP_MASKED_COPY: p = 2'd1;
         OP_COMPOSE:              p = 2'd2;
         default:                 p = 2'd3;
      endcase
      return p;
   endfunction

   // sequencer state
   state_type     state_ff, state_in;
   logic          rsp_valid_ff, rsp_valid_in;
   op_type        op_ff, op_in;
   logic          sel_d_ff, sel_d_in, sel_s_ff, sel_s_in, sel_b_ff, sel_b_in;
   logic          a_surf_ff, a_surf_in;
   logic          pass_ff, pass_in;
   logic [2:0]    step_ff, step_in;
   clip_rect_type rect_ff, rect_in, rect_next;
   crd_type       src_x_ff, src_x_in, src_y_ff, src_y_in;
   crd_type       g_x_ff, g_x_in, g_y_ff, g_y_in;
   crd_type       dst_x_ff, dst_x_in, dst_y_ff, dst_y_in;
   logic [PIX_W-1:0] pix_val_ff, pix_val_in;
   addr_type      base_d_ff, base_d_in, base_a_ff, base_a_in, base_g_ff, base_g_in;
   crd_type       col_ff, col_in, row_ff, row_in;
   logic [1:0]    phase_ff, phase_in;
   logic [PIX_W-1:0] sv_ff, sv_in, t_ff, t_in;
   logic          rd_surf_ff;

   logic [PIX_W-1:0]     res_read_ff, res_read_in;
   logic [DRAWN_W_W-1:0] res_dw_ff, res_dw_in;
   logic [DRAWN_H_W-1:0] res_dh_ff, res_dh_in;
   logic                 res_status_ff, res_status_in;
   logic [PIX_W-1:0]     rsp_read_ff, rsp_read_in;
   logic [DRAWN_W_W-1:0] rsp_dw_ff, rsp_dw_in;
   logic [DRAWN_H_W-1:0] rsp_dh_ff, rsp_dh_in;
   logic                 rsp_status_ff, rsp_status_in;

   // surface roles
   crd_type sw_d, sh_d, sw_a, sw_g;
   clip_bounds_type bounds;

   assign sw_d = sel_d_ff  ? eff_w1 : eff_w0;
   assign sh_d = sel_d_ff  ? eff_h1 : eff_h0;
   assign sw_a = a_surf_ff ? eff_w1 : eff_w0;
   assign sw_g = sel_b_ff  ? eff_w1 : eff_w0;
   assign bounds.wa = sw_a;
   assign bounds.ha = a_surf_ff ? eff_h1 : eff_h0;
   assign bounds.wb = sw_d;
   assign bounds.hb = sh_d;

   crb_clip_unit u_clip (
      .step      (clip_step_type'(step_ff)),
      .rect_cur  (rect_ff),
      .bounds    (bounds),
      .rect_next (rect_next)
   );

   // surface stores
   logic             wr_en, wr_surf, rd_surf;
   addr_type         wr_addr, rd_addr;
   logic [PIX_W-1:0] wr_data, q0, q1, rdata;

   crb_ram #(.WIDTH(PIX_W), .DEPTH(SURF_DEPTH)) u_surf0 (
      .clock   (clock),
      .wr_en   (wr_en && !wr_surf),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (q0)
   );

   crb_ram #(.WIDTH(PIX_W), .DEPTH(SURF_DEPTH)) u_surf1 (
      .clock   (clock),
      .wr_en   (wr_en && wr_surf),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (q1)
   );

   assign rdata = rd_surf_ff ? q1 : q0;

   // shared multiply-add for row addresses
   addr_type mul_y, mul_w, mul_x, mul_out;
   assign mul_out = mul_y * mul_w + mul_x;

   addr_type addr_d, addr_a, addr_g;
   assign addr_d = base_d_ff + ADDR_W'($unsigned(col_ff));
   assign addr_a = base_a_ff + ADDR_W'($unsigned(col_ff));
   assign addr_g = base_g_ff + ADDR_W'($unsigned(col_ff));

   crd_type req_dx, req_dy, req_sx, req_sy, req_gx, req_gy;
   assign req_dx = CRD_W'(req_bus.dst_x);
   assign req_dy = CRD_W'(req_bus.dst_y);
   assign req_sx = CRD_W'(req_bus.src_x);
   assign req_sy = CRD_W'(req_bus.src_y);
   assign req_gx = CRD_W'(req_bus.bg_x);
   assign req_gy = CRD_W'(req_bus.bg_y);

   assign req_bus.ready = (state_ff == ST_IDLE);

   always_comb begin
      state_in      = state_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_bus.ready;
      op_in         = op_ff;
      sel_d_in      = sel_d_ff;
      sel_s_in      = sel_s_ff;
      sel_b_in      = sel_b_ff;
      a_surf_in     = a_surf_ff;
      pass_in       = pass_ff;
      step_in       = step_ff;
      rect_in       = rect_ff;
      src_x_in      = src_x_ff;
      src_y_in      = src_y_ff;
      g_x_in        = g_x_ff;
      g_y_in        = g_y_ff;
      dst_x_in      = dst_x_ff;
      dst_y_in      = dst_y_ff;
      pix_val_in    = pix_val_ff;
      base_d_in     = base_d_ff;
      base_a_in     = base_a_ff;
      base_g_in     = base_g_ff;
      col_in        = col_ff;
      row_in        = row_ff;
      phase_in      = phase_ff;
      sv_in         = sv_ff;
      t_in          = t_ff;
      res_read_in   = res_read_ff;
      res_dw_in     = res_dw_ff;
      res_dh_in     = res_dh_ff;
      res_status_in = res_status_ff;
      rsp_read_in   = rsp_read_ff;
      rsp_dw_in     = rsp_dw_ff;
      rsp_dh_in     = rsp_dh_ff;
      rsp_status_in = rsp_status_ff;
      wr_en   = 1'b0;
      wr_surf = 1'b0;
      wr_addr = '0;
      wr_data = '0;
      rd_surf = 1'b0;
      rd_addr = '0;
      mul_y   = '0;
      mul_w   = '0;
      mul_x   = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_bus.valid) begin
               op_in         = op_type'(req_bus.op);
               sel_d_in      = req_bus.surface_sel[0];
               sel_s_in      = req_bus.surface_sel[1];
               sel_b_in      = req_bus.surface_sel[2];
               src_x_in      = req_sx;
               src_y_in      = req_sy;
               dst_x_in      = req_dx;
               dst_y_in      = req_dy;
               pix_val_in    = req_bus.pixel_value;
               pass_in       = 1'b0;
               step_in       = '0;
               res_read_in   = '0;
               res_dw_in     = '0;
               res_dh_in     = '0;
               res_status_in = 1'b1;
               rect_in.w     = CRD_W'(req_bus.width);
               rect_in.h     = CRD_W'(req_bus.height);
               rect_in.bx    = req_dx - (req_bus.surface_sel[0] ? off_x1 : off_x0);
               rect_in.by    = req_dy - (req_bus.surface_sel[0] ? off_y1 : off_y0);
               rect_in.ax    = req_sx - (req_bus.surface_sel[1] ? off_x1 : off_x0);
               rect_in.ay    = req_sy - (req_bus.surface_sel[1] ? off_y1 : off_y0);
               a_surf_in     = req_bus.surface_sel[1];
               state_in      = ST_CLIP;
               unique case (op_type'(req_bus.op))
                  OP_FILL: begin
                     rect_in.ax = req_dx;
                     rect_in.ay = req_dy;
                     rect_in.bx = req_dx;
                     rect_in.by = req_dy;
                     a_surf_in  = req_bus.surface_sel[0];
                  end
                  OP_COPY, OP_MASKED_COPY, OP_SWAP: ;
                  OP_COMPOSE: begin
                     rect_in.ax = req_gx - (req_bus.surface_sel[2] ? off_x1 : off_x0);
                     rect_in.ay = req_gy - (req_bus.surface_sel[2] ? off_y1 : off_y0);
                     a_surf_in  = req_bus.surface_sel[2];
                  end
                  OP_WRITE_PIXEL, OP_READ_PIXEL: state_in = ST_PIXEL_CHECK;
                  OP_NOP: state_in = ST_FINISH;
               endcase
            end
         end

         ST_CLIP: begin
            rect_in = rect_next;
            step_in = step_ff + 3'd1;
            if (&step_ff) begin
               if (op_ff == OP_COMPOSE && !pass_ff) begin
                  pass_in    = 1'b1;
                  g_x_in     = rect_next.ax;
                  g_y_in     = rect_next.ay;
                  rect_in.ax = src_x_ff - (sel_s_ff ? off_x1 : off_x0);
                  rect_in.ay = src_y_ff - (sel_s_ff ? off_y1 : off_y0);
                  a_surf_in  = sel_s_ff;
               end else begin
                  state_in = ST_SETUP;
               end
            end
         end

         ST_SETUP: begin
            if (rect_ff.w < 1 || rect_ff.h < 1) begin
               state_in = ST_FINISH;
            end else begin
               step_in = step_ff + 3'd1;
               priority if (step_ff == 3'd0) begin
                  mul_y     = ADDR_W'($unsigned(rect_ff.by));
                  mul_w     = ADDR_W'($unsigned(sw_d));
                  mul_x     = ADDR_W'($unsigned(rect_ff.bx));
                  base_d_in = mul_out;
               end else if (step_ff == 3'd1) begin
                  mul_y     = ADDR_W'($unsigned(rect_ff.ay));
                  mul_w     = ADDR_W'($unsigned(sw_a));
                  mul_x     = ADDR_W'($unsigned(rect_ff.ax));
                  base_a_in = mul_out;
               end else begin
                  mul_y     = ADDR_W'($unsigned(g_y_ff));
                  mul_w     = ADDR_W'($unsigned(sw_g));
                  mul_x     = ADDR_W'($unsigned(g_x_ff));
                  base_g_in = mul_out;
                  col_in    = '0;
                  row_in    = '0;
                  phase_in  = '0;
                  state_in  = ST_WALK;
               end
            end
         end

         ST_WALK: begin
            unique case (op_ff)
               OP_FILL: begin
                  wr_en   = 1'b1;
                  wr_surf = sel_d_ff;
                  wr_addr = addr_d;
                  wr_data = MASK_COLOUR;
               end
               OP_COPY, OP_MASKED_COPY: begin
                  if (phase_ff == 2'd0) begin
                     rd_surf = sel_s_ff;
                     rd_addr = addr_a;
                  end else begin
                     wr_en   = (op_ff == OP_COPY) || (rdata != MASK_COLOUR);
                     wr_surf = sel_d_ff;
                     wr_addr = addr_d;
                     wr_data = rdata;
                  end
               end
               OP_SWAP: begin
                  unique case (phase_ff)
                     2'd0: begin
                        rd_surf = sel_s_ff;
                        rd_addr = addr_a;
                     end
                     2'd1: begin
                        rd_surf = sel_d_ff;
                        rd_addr = addr_d;
                        sv_in   = rdata;
                     end
                     2'd2: begin
                        wr_en   = 1'b1;
                        wr_surf = sel_d_ff;
                        wr_addr = addr_d;
                        wr_data = sv_ff;
                        t_in    = rdata;
                     end
                     default: begin
                        wr_en   = 1'b1;
                        wr_surf = sel_s_ff;
                        wr_addr = addr_a;
                        wr_data = t_ff;
                     end
                  endcase
               end
               OP_COMPOSE: begin
                  unique case (phase_ff)
                     2'd0: begin
                        rd_surf = sel_s_ff;
                        rd_addr = addr_a;
                     end
                     2'd1: begin
                        rd_surf = sel_b_ff;
                        rd_addr = addr_g;
                        sv_in   = rdata;
                     end
                     default: begin
                        wr_en   = 1'b1;
                        wr_surf = sel_d_ff;
                        wr_addr = addr_d;
                        wr_data = (sv_ff == MASK_COLOUR) ? rdata : sv_ff;
                     end
                  endcase
               end
               default: ;
            endcase

            phase_in = phase_ff + 2'd1;
            if (phase_ff == last_phase(op_ff)) begin
               phase_in = '0;
               if (col_ff == rect_ff.w - 1) begin
                  col_in    = '0;
                  row_in    = row_ff + CRD_W'(1);
                  base_d_in = base_d_ff + ADDR_W'($unsigned(sw_d));
                  base_a_in = base_a_ff + ADDR_W'($unsigned(sw_a));
                  base_g_in = base_g_ff + ADDR_W'($unsigned(sw_g));
                  if (row_ff == rect_ff.h - 1) begin
                     res_dw_in     = DRAWN_W_W'($unsigned(rect_ff.w));
                     res_dh_in     = DRAWN_H_W'($unsigned(rect_ff.h));
                     res_status_in = 1'b0;
                     state_in      = ST_FINISH;
                  end
               end else begin
                  col_in = col_ff + CRD_W'(1);
               end
            end
         end

         ST_PIXEL_CHECK: begin
            if (dst_x_ff < 0 || dst_y_ff < 0 || dst_x_ff >= sw_d || dst_y_ff >= sh_d) begin
               state_in = ST_FINISH;
            end else begin
               state_in = ST_PIXEL_ADDR;
            end
         end

         ST_PIXEL_ADDR: begin
            mul_y     = ADDR_W'($unsigned(dst_y_ff));
            mul_w     = ADDR_W'($unsigned(sw_d));
            mul_x     = ADDR_W'($unsigned(dst_x_ff));
            base_d_in = mul_out;
            col_in    = '0;
            state_in  = ST_PIXEL_ACCESS;
         end

         ST_PIXEL_ACCESS: begin
            if (op_ff == OP_WRITE_PIXEL) begin
               wr_en         = 1'b1;
               wr_surf       = sel_d_ff;
               wr_addr       = base_d_ff;
               wr_data       = pix_val_ff;
               res_dw_in     = DRAWN_W_W'(1);
               res_dh_in     = DRAWN_H_W'(1);
               res_status_in = 1'b0;
               state_in      = ST_FINISH;
            end else begin
               rd_surf  = sel_d_ff;
               rd_addr  = base_d_ff;
               state_in = ST_PIXEL_READ;
            end
         end

         ST_PIXEL_READ: begin
            res_read_in   = rdata;
            res_status_in = 1'b0;
            state_in      = ST_FINISH;
         end

         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_bus.ready) begin
               rsp_valid_in  = 1'b1;
               rsp_read_in   = res_read_ff;
               rsp_dw_in     = res_dw_ff;
               rsp_dh_in     = res_dh_ff;
               rsp_status_in = res_status_ff;
               state_in      = ST_IDLE;
            end
         end

         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      sel_d_ff      <= sel_d_in;
      sel_s_ff      <= sel_s_in;
      sel_b_ff      <= sel_b_in;
      a_surf_ff     <= a_surf_in;
      pass_ff       <= pass_in;
      step_ff       <= step_in;
      rect_ff       <= rect_in;
      src_x_ff      <= src_x_in;
      src_y_ff      <= src_y_in;
      g_x_ff        <= g_x_in;
      g_y_ff        <= g_y_in;
      dst_x_ff      <= dst_x_in;
      dst_y_ff      <= dst_y_in;
      pix_val_ff    <= pix_val_in;
      base_d_ff     <= base_d_in;
      base_a_ff     <= base_a_in;
      base_g_ff     <= base_g_in;
      col_ff        <= col_in;
      row_ff        <= row_in;
      phase_ff      <= phase_in;
      sv_ff         <= sv_in;
      t_ff          <= t_in;
      rd_surf_ff    <= rd_surf;
      res_read_ff   <= res_read_in;
      res_dw_ff     <= res_dw_in;
      res_dh_ff     <= res_dh_in;
      res_status_ff <= res_status_in;
      rsp_read_ff   <= rsp_read_in;
      rsp_dw_ff     <= rsp_dw_in;
      rsp_dh_ff     <= rsp_dh_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_bus.valid        = rsp_valid_ff;
   assign rsp_bus.read_data    = rsp_read_ff;
   assign rsp_bus.drawn_width  = rsp_dw_ff;
   assign rsp_bus.drawn_height = rsp_dh_ff;
   assign rsp_bus.status       = rsp_status_ff;

   // surfaces are only written while walking or on a pixel write
   assert property (@(posedge clock) disable iff (reset)
      wr_en |-> (state_ff == ST_WALK || state_ff == ST_PIXEL_ACCESS))
      else $error("surface write outside a drawing state");

   // the walk never leaves the clipped rectangle
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WALK) |-> (col_ff < rect_ff.w && row_ff < rect_ff.h))
      else $error("pixel walk beyond clipped rectangle");

   // a taken request starts the sequencer
   assert property (@(posedge clock) disable iff (reset)
      (req_bus.valid && req_bus.ready) |=> (state_ff != ST_IDLE))
      else $error("request taken but sequencer stayed idle");

   // nothing drawn means no drawn size
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_status_ff) |-> (rsp_dw_ff == '0 && rsp_dh_ff == '0))
      else $error("empty response with a drawn size");

endmodule
`default_nettype wire

@@ rtl/crb_ram.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// crb_ram
// Generic single write, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module crb_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

@@ rtl/crb_clip_unit.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// crb_clip_unit
// Shared clipping step: one edge adjustment of a rectangle pair per cycle.
// ----------------------------------------------------------------------------
module crb_clip_unit import crb_pkg::*; (
   input  clip_step_type   step,
   input  clip_rect_type   rect_cur,
   input  clip_bounds_type bounds,
   output clip_rect_type   rect_next
);

   always_comb begin
      rect_next = rect_cur;
      unique case (step)
         CLIP_LEFT_A: begin
            if (rect_cur.ax < 0) begin
               rect_next.w  = rect_cur.w + rect_cur.ax;
               rect_next.bx = rect_cur.bx - rect_cur.ax;
               rect_next.ax = '0;
            end
         end
         CLIP_TOP_A: begin
            if (rect_cur.ay < 0) begin
               rect_next.h  = rect_cur.h + rect_cur.ay;
               rect_next.by = rect_cur.by - rect_cur.ay;
               rect_next.ay = '0;
            end
         end
         CLIP_LEFT_B: begin
            if (rect_cur.bx < 0) begin
               rect_next.w  = rect_cur.w + rect_cur.bx;
               rect_next.ax = rect_cur.ax - rect_cur.bx;
               rect_next.bx = '0;
            end
         end
         CLIP_TOP_B: begin
            if (rect_cur.by < 0) begin
               rect_next.h  = rect_cur.h + rect_cur.by;
               rect_next.ay = rect_cur.ay - rect_cur.by;
               rect_next.by = '0;
            end
         end
         CLIP_RIGHT_A: begin
            if (rect_cur.ax + rect_cur.w > bounds.wa) begin
               rect_next.w = bounds.wa - rect_cur.ax;
            end
         end
         CLIP_BOTTOM_A: begin
            if (rect_cur.ay + rect_cur.h > bounds.ha) begin
               rect_next.h = bounds.ha - rect_cur.ay;
            end
         end
         CLIP_RIGHT_B: begin
            if (rect_cur.bx + rect_cur.w > bounds.wb) begin
               rect_next.w = bounds.wb - rect_cur.bx;
            end
         end
         CLIP_BOTTOM_B: begin
            if (rect_cur.by + rect_cur.h > bounds.hb) begin
               rect_next.h = bounds.hb - rect_cur.by;
            end
         end
      endcase
   end

endmodule
`default_nettype wire
